@@ rtl/dwsr_pkg.sv @@
// Shared constants, types and codes for the deque with search and remove.
package dwsr_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ACT_W       = 3;
  localparam int STAT_W      = 2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CONTAINS   = 3'd4,
    ACT_REMOVE     = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

endpackage

@@ rtl/dwsr_if.sv @@
// Valid/ready channel interfaces for the request and result beats.
interface dwsr_in_if;
  logic                      valid;
  logic                      ready;
  logic [dwsr_pkg::ACT_W-1:0] action;
  dwsr_pkg::value_t          value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dwsr_out_if;
  logic                        valid;
  logic                        ready;
  logic [dwsr_pkg::STAT_W-1:0] status;
  logic                        found;
  dwsr_pkg::cnt_t              count;
  logic                        empty_res;
  dwsr_pkg::value_t            front_value;
  dwsr_pkg::value_t            back_value;

  modport source (output valid, output status, output found, output count,
                  output empty_res, output front_value, output back_value,
                  input ready);
  modport sink   (input valid, input status, input found, input count,
                  input empty_res, input front_value, input back_value,
                  output ready);
endinterface

@@ rtl/deque_with_search_and_remove_unit.sv @@
// Deque top level: element memory, search and remove sequencer, result register.
//
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | action[2:0], value[31:0]
//  out_ch  | out | valid/ready  | status, found, count, empty_res, front_value, back_value
//
//  Push and pop go from accept to result through update, read ends, load.
//  Contains scans with one memory read issued per cycle, compare next.
//  Remove then shifts later elements down one place.
//  Memory port A serves scan, shift and the front read; port B reads the back.
//  Reset clears head, count and control; the element memory needs no clearing.
//  A new beat is taken whenever the sequencer is idle, even while a result waits.
module deque_with_search_and_remove_unit (
  input  logic        clk,
  input  logic        rst_n,
  dwsr_in_if.sink     in_ch,
  dwsr_out_if.source  out_ch
);

  localparam int SUM_W = dwsr_pkg::CNT_W + 1;

  function automatic dwsr_pkg::addr_t slot(input dwsr_pkg::addr_t head,
                                           input dwsr_pkg::cnt_t ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(ofs);
    if (sum >= SUM_W'(dwsr_pkg::DEPTH)) begin
      sum = sum - SUM_W'(dwsr_pkg::DEPTH);
    end
    return sum[dwsr_pkg::ADDR_W-1:0];
  endfunction

  dwsr_pkg::value_t mem [dwsr_pkg::DEPTH];
  dwsr_pkg::value_t rd_a_r;
  dwsr_pkg::value_t rd_b_r;

  dwsr_pkg::state_t  state_r, state_nxt;
  dwsr_pkg::addr_t   head_r, head_nxt;
  dwsr_pkg::cnt_t    cnt_r, cnt_nxt;
  dwsr_pkg::cnt_t    idx_r, idx_nxt;
  dwsr_pkg::cnt_t    pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic [dwsr_pkg::ACT_W-1:0] act_r, act_nxt;
  dwsr_pkg::value_t  val_r, val_nxt;
  dwsr_pkg::status_t stat_r, stat_nxt;
  logic              found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [dwsr_pkg::STAT_W-1:0] out_status_r;
  logic              out_found_r;
  dwsr_pkg::cnt_t    out_count_r;
  logic              out_empty_r;
  dwsr_pkg::value_t  out_front_r;
  dwsr_pkg::value_t  out_back_r;

  logic              accept;
  logic              full;
  logic              is_empty;
  logic              more;
  logic              hit;
  logic              load;
  logic              re;
  logic              we;
  dwsr_pkg::addr_t   ra_a;
  dwsr_pkg::addr_t   ra_b;
  dwsr_pkg::addr_t   wa;
  dwsr_pkg::value_t  wd;
  dwsr_pkg::addr_t   head_dec;
  dwsr_pkg::cnt_t    back_ofs;

  assign accept   = in_ch.valid && in_ch.ready;
  assign full     = cnt_r >= dwsr_pkg::CNT_W'(dwsr_pkg::DEPTH);
  assign is_empty = cnt_r == '0;
  assign more     = idx_r < cnt_r;
  assign hit      = pend_r && (rd_a_r == val_r);
  assign load     = (state_r == dwsr_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign head_dec = (head_r == '0) ? dwsr_pkg::ADDR_W'(dwsr_pkg::DEPTH - 1)
                                   : head_r - dwsr_pkg::ADDR_W'(1);
  assign back_ofs = is_empty ? '0 : cnt_r - dwsr_pkg::CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwsr_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_ch.action == dwsr_pkg::ACT_CONTAINS ||
               in_ch.action == dwsr_pkg::ACT_REMOVE) && !is_empty) begin
            state_nxt = dwsr_pkg::S_SCAN;
          end else begin
            state_nxt = dwsr_pkg::S_READ;
          end
        end
      end
      dwsr_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = (act_r == dwsr_pkg::ACT_REMOVE) ? dwsr_pkg::S_SHIFT
                                                       : dwsr_pkg::S_READ;
        end else if (!more) begin
          state_nxt = dwsr_pkg::S_READ;
        end
      end
      dwsr_pkg::S_SHIFT: begin
        if (!more) begin
          state_nxt = dwsr_pkg::S_READ;
        end
      end
      dwsr_pkg::S_READ: state_nxt = dwsr_pkg::S_DONE;
      dwsr_pkg::S_DONE: begin
        if (load) begin
          state_nxt = dwsr_pkg::S_IDLE;
        end
      end
      default: state_nxt = dwsr_pkg::S_IDLE;
    endcase
  end

  // memory controls and ready
  always_comb begin
    re   = 1'b0;
    we   = 1'b0;
    ra_a = slot(head_r, idx_r);
    ra_b = slot(head_r, back_ofs);
    wa   = slot(head_r, pidx_r - dwsr_pkg::CNT_W'(1));
    wd   = rd_a_r;
    case (state_r)
      dwsr_pkg::S_IDLE: begin
        wd = in_ch.value;
        if (accept && !full) begin
          if (in_ch.action == dwsr_pkg::ACT_PUSH_FRONT) begin
            we = 1'b1;
            wa = head_dec;
          end else if (in_ch.action == dwsr_pkg::ACT_PUSH_BACK) begin
            we = 1'b1;
            wa = slot(head_r, cnt_r);
          end
        end
      end
      dwsr_pkg::S_SCAN: re = more;
      dwsr_pkg::S_SHIFT: begin
        re = more;
        we = pend_r;
      end
      dwsr_pkg::S_READ: begin
        re   = 1'b1;
        ra_a = head_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = state_r == dwsr_pkg::S_IDLE;

  // datapath next values
  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = 1'b0;
    act_nxt       = act_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      dwsr_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt   = in_ch.action;
          val_nxt   = in_ch.value;
          stat_nxt  = dwsr_pkg::STAT_DONE;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          case (in_ch.action)
            dwsr_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                stat_nxt = dwsr_pkg::STAT_FULL;
              end else begin
                head_nxt = head_dec;
                cnt_nxt  = cnt_r + dwsr_pkg::CNT_W'(1);
              end
            end
            dwsr_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                stat_nxt = dwsr_pkg::STAT_FULL;
              end else begin
                cnt_nxt = cnt_r + dwsr_pkg::CNT_W'(1);
              end
            end
            dwsr_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                stat_nxt = dwsr_pkg::STAT_EMPTY;
              end else begin
                head_nxt = slot(head_r, dwsr_pkg::CNT_W'(1));
                cnt_nxt  = cnt_r - dwsr_pkg::CNT_W'(1);
              end
            end
            dwsr_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                stat_nxt = dwsr_pkg::STAT_EMPTY;
              end else begin
                cnt_nxt = cnt_r - dwsr_pkg::CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      dwsr_pkg::S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          idx_nxt   = pidx_r + dwsr_pkg::CNT_W'(1);
        end else if (more) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + dwsr_pkg::CNT_W'(1);
        end
      end
      dwsr_pkg::S_SHIFT: begin
        if (more) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + dwsr_pkg::CNT_W'(1);
        end else begin
          cnt_nxt = cnt_r - dwsr_pkg::CNT_W'(1);
        end
      end
      dwsr_pkg::S_DONE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwsr_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    act_r   <= act_nxt;
    val_r   <= val_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    if (load) begin
      out_status_r <= stat_r;
      out_found_r  <= found_r;
      out_count_r  <= cnt_r;
      out_empty_r  <= is_empty;
      out_front_r  <= is_empty ? '0 : rd_a_r;
      out_back_r   <= is_empty ? '0 : rd_b_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.empty_res   = out_empty_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;

endmodule

@@ rtl/dwsr_checker.sv @@
// Port-level assertions for the deque, bound to the top level.
module dwsr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dwsr_pkg::STAT_W-1:0] out_status,
  input logic                        out_found,
  input dwsr_pkg::cnt_t              out_count,
  input logic                        out_empty_res,
  input dwsr_pkg::value_t            out_front_value,
  input dwsr_pkg::value_t            out_back_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) &&
      $stable(out_front_value) && $stable(out_back_value) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_empty_res == (out_count == '0))
    else $error("empty flag disagrees with count");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_front_value == '0 && out_back_value == '0)
    else $error("empty deque reports non-zero ends");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= dwsr_pkg::CNT_W'(dwsr_pkg::DEPTH))
    else $error("count beyond depth");

  a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dwsr_pkg::STAT_DONE |-> !out_found)
    else $error("refused beat reports a match");

endmodule

bind deque_with_search_and_remove_unit dwsr_checker u_dwsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_count       (out_ch.count),
  .out_empty_res   (out_ch.empty_res),
  .out_front_value (out_ch.front_value),
  .out_back_value  (out_ch.back_value)
);

@@ bench/tb_deque_with_search_and_remove_unit.sv @@
// Self-checking bench for the deque unit: table-driven directed rows, then random beats.
module tb_deque_with_search_and_remove_unit;

  localparam logic [dwsr_pkg::ACT_W-1:0] ACT_UNUSED_A = 3'd6;
  localparam logic [dwsr_pkg::ACT_W-1:0] ACT_UNUSED_B = 3'd7;
  localparam int RANDOM_BEATS = 1610;
  localparam int ROW_COUNT    = 22;

  typedef struct packed {
    logic [dwsr_pkg::STAT_W-1:0] status;
    logic                        found;
    dwsr_pkg::cnt_t              count;
    logic                        empty_res;
    dwsr_pkg::value_t            front_value;
    dwsr_pkg::value_t            back_value;
  } deque_report_t;

  typedef struct {
    logic [dwsr_pkg::ACT_W-1:0] action;
    dwsr_pkg::value_t           value;
    int                         reps;
    int                         step;
    bit                         typed;
    deque_report_t              expected;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dwsr_in_if  req_if ();
  dwsr_out_if rsp_if ();

  deque_with_search_and_remove_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  always #2 clk = ~clk;

  dwsr_pkg::value_t mirror_deque [$];
  deque_report_t    pending_reports [$];
  int               mismatch_count = 0;
  int               burst_left = 0;
  bit               growing = 1'b1;
  bit               random_phase = 1'b0;
  int               stall_cycle = 0;
  int               hold_left = 0;

  stim_row_t directed_rows [ROW_COUNT] = '{
    '{dwsr_pkg::ACT_POP_FRONT,  32'sd0,          1, 0, 1'b1,
      '{dwsr_pkg::STAT_EMPTY, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{dwsr_pkg::ACT_POP_BACK,   32'sd0,          1, 0, 1'b1,
      '{dwsr_pkg::STAT_EMPTY, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{dwsr_pkg::ACT_CONTAINS,   32'sd0,          1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{dwsr_pkg::ACT_REMOVE,     32'sd0,          1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{ACT_UNUSED_A,             -32'sd1,         1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{ACT_UNUSED_B,             32'sh5555_AAAA,  1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd0, 1'b1, 32'sd0, 32'sd0}},
    '{dwsr_pkg::ACT_PUSH_BACK,  32'sh7FFF_FFFF,  1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd1, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
    '{dwsr_pkg::ACT_PUSH_FRONT, 32'sh8000_0000,  1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b0, 5'd2, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF}},
    '{dwsr_pkg::ACT_CONTAINS,   32'sh8000_0000,  1, 0, 1'b1,
      '{dwsr_pkg::STAT_DONE, 1'b1, 5'd2, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF}},
    '{dwsr_pkg::ACT_PUSH_BACK,  -32'sd1,         1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_PUSH_FRONT, 32'sd5,         13, 1, 1'b0, '0},
    '{dwsr_pkg::ACT_PUSH_BACK,  32'sd99,         1, 0, 1'b1,
      '{dwsr_pkg::STAT_FULL, 1'b0, 5'd16, 1'b0, 32'sd17, -32'sd1}},
    '{dwsr_pkg::ACT_PUSH_FRONT, 32'sd99,         1, 0, 1'b1,
      '{dwsr_pkg::STAT_FULL, 1'b0, 5'd16, 1'b0, 32'sd17, -32'sd1}},
    '{dwsr_pkg::ACT_CONTAINS,   -32'sd1,         1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_REMOVE,     32'sd10,         1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_REMOVE,     32'sd17,         1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_REMOVE,     -32'sd1,         1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_REMOVE,     32'sd1234,       1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_PUSH_BACK,  32'sd6,          2, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_REMOVE,     32'sd6,          1, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_POP_FRONT,  32'sd0,          2, 0, 1'b0, '0},
    '{dwsr_pkg::ACT_POP_BACK,   32'sd0,          2, 0, 1'b0, '0}
  };

  function automatic deque_report_t perform_action(
      input logic [dwsr_pkg::ACT_W-1:0] action,
      input dwsr_pkg::value_t           value);
    deque_report_t r;
    int            hit;
    r.status = dwsr_pkg::STAT_DONE;
    r.found  = 1'b0;
    hit      = -1;
    case (action)
      dwsr_pkg::ACT_PUSH_FRONT, dwsr_pkg::ACT_PUSH_BACK: begin
        if (mirror_deque.size() >= dwsr_pkg::DEPTH) begin
          r.status = dwsr_pkg::STAT_FULL;
        end else if (action == dwsr_pkg::ACT_PUSH_FRONT) begin
          mirror_deque.push_front(value);
        end else begin
          mirror_deque.push_back(value);
        end
      end
      dwsr_pkg::ACT_POP_FRONT, dwsr_pkg::ACT_POP_BACK: begin
        if (mirror_deque.size() == 0) begin
          r.status = dwsr_pkg::STAT_EMPTY;
        end else if (action == dwsr_pkg::ACT_POP_FRONT) begin
          void'(mirror_deque.pop_front());
        end else begin
          void'(mirror_deque.pop_back());
        end
      end
      dwsr_pkg::ACT_CONTAINS, dwsr_pkg::ACT_REMOVE: begin
        foreach (mirror_deque[i]) begin
          if (hit < 0 && mirror_deque[i] == value) hit = i;
        end
        r.found = (hit >= 0);
        if (action == dwsr_pkg::ACT_REMOVE && hit >= 0) mirror_deque.delete(hit);
      end
      default: ;
    endcase
    r.count     = dwsr_pkg::cnt_t'(mirror_deque.size());
    r.empty_res = (mirror_deque.size() == 0);
    if (mirror_deque.size() == 0) begin
      r.front_value = '0;
      r.back_value  = '0;
    end else begin
      r.front_value = mirror_deque[0];
      r.back_value  = mirror_deque[$];
    end
    return r;
  endfunction

  task automatic offer_beat(input logic [dwsr_pkg::ACT_W-1:0] action,
                            input dwsr_pkg::value_t value,
                            output deque_report_t predicted);
    req_if.valid  <= 1'b1;
    req_if.action <= action;
    req_if.value  <= value;
    do @(posedge clk); while (!req_if.ready);
    predicted = perform_action(action, value);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic pick_random_beat(output logic [dwsr_pkg::ACT_W-1:0] action,
                                  output dwsr_pkg::value_t value);
    int fill;
    int roll;
    int pick;
    fill = mirror_deque.size();
    if (fill == dwsr_pkg::DEPTH) growing = 1'b0;
    else if (fill == 0) growing = 1'b1;
    else if ($urandom_range(0, 63) == 0) growing = !growing;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      action = (roll == 0) ? ACT_UNUSED_A : ACT_UNUSED_B;
    end else if (roll < 62) begin
      if ((roll < 52) == growing) begin
        action = $urandom_range(0, 1) ? dwsr_pkg::ACT_PUSH_FRONT : dwsr_pkg::ACT_PUSH_BACK;
      end else begin
        action = $urandom_range(0, 1) ? dwsr_pkg::ACT_POP_FRONT : dwsr_pkg::ACT_POP_BACK;
      end
    end else if (roll < 80) begin
      action = dwsr_pkg::ACT_CONTAINS;
    end else begin
      action = dwsr_pkg::ACT_REMOVE;
    end
    pick = $urandom_range(0, 9);
    if (pick < 4 && fill > 0) begin
      value = mirror_deque[$urandom_range(0, fill - 1)];
    end else if (pick < 7) begin
      value = dwsr_pkg::value_t'(int'($urandom_range(0, 15)) - 8);
    end else if (pick == 7) begin
      value = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      value = dwsr_pkg::value_t'($urandom());
    end
  endtask

  task automatic compare_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: rotate through stall patterns, with a long hold-off now and then
  always @(posedge clk) begin
    stall_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (random_phase && stall_cycle % 4096 == 2048) begin
      hold_left = 150;
      rsp_if.ready <= 1'b0;
    end else begin
      case ((stall_cycle / 256) % 4)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= $urandom_range(0, 1);
        2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    deque_report_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat arrived with nothing outstanding");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("status",      want.status,               rsp_if.status);
        compare_field("found",       want.found,                rsp_if.found);
        compare_field("count",       want.count,                rsp_if.count);
        compare_field("empty_res",   want.empty_res,            rsp_if.empty_res);
        compare_field("front_value", $signed(want.front_value), $signed(rsp_if.front_value));
        compare_field("back_value",  $signed(want.back_value),  $signed(rsp_if.back_value));
      end
    end
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    deque_report_t              predicted;
    logic [dwsr_pkg::ACT_W-1:0] action;
    dwsr_pkg::value_t           value;
    req_if.valid  = 1'b0;
    req_if.action = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        offer_beat(directed_rows[r].action,
                   directed_rows[r].value + dwsr_pkg::value_t'(k * directed_rows[r].step),
                   predicted);
        pending_reports.push_back(directed_rows[r].typed ? directed_rows[r].expected
                                                         : predicted);
        pace_sender();
      end
    end

    random_phase <= 1'b1;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick_random_beat(action, value);
      offer_beat(action, value, predicted);
      pending_reports.push_back(predicted);
      pace_sender();
    end
    req_if.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dwsr_pkg.sv
rtl/dwsr_if.sv
rtl/deque_with_search_and_remove_unit.sv
rtl/dwsr_checker.sv
bench/tb_deque_with_search_and_remove_unit.sv
